// File: sv/mazp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze planner package
// Shared types, constants and small helper functions for the maze planner.
// ----------------------------------------------------------------------------
package mazp_pkg;

    localparam int GRID_SIDE      = 16;
    localparam int COORD_W        = 4;
    localparam int CELL_W         = 2 * COORD_W;
    localparam int NCELL          = GRID_SIDE * GRID_SIDE;
    localparam int LEN_W          = 9;
    localparam int COST_W         = 8;
    localparam int TOT_W          = 9;
    localparam int HDIST_W        = COORD_W + 1;
    localparam int HEAP_DEPTH_DEF = 1024;

    localparam logic [COORD_W-1:0] GRID_MAX = COORD_W'(GRID_SIDE - 1);

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_MARK  = 2'd1,
        REQ_PLAN  = 2'd2,
        REQ_READ  = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_E = 2'd1,
        DIR_S = 2'd2,
        DIR_W = 2'd3
    } dir_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] cell_x;
        logic [3:0] cell_y;
        logic [1:0] wall_dir;
        logic [3:0] goal_x;
        logic [3:0] goal_y;
        logic [7:0] path_index;
    } mazp_req_t;

    typedef struct packed {
        logic [8:0] path_len;
        logic       path_found;
        logic       entry_valid;
        logic [3:0] path_x;
        logic [3:0] path_y;
    } mazp_rsp_t;

    // Control from the front end to the search engine.
    typedef struct packed {
        logic go;
        logic take;
    } eng_ctl_t;

    // Status from the search engine to the front end.
    typedef struct packed {
        logic busy;
        logic done;
    } eng_sts_t;

    // Returns {on_grid, nx, ny} for the neighbor of (x, y) on side d.
    function automatic logic [CELL_W:0] step_cell(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y,
                                                  input logic [1:0] d);
        logic               ok;
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        begin
            ok = 1'b0;
            nx = x;
            ny = y;
            unique case (dir_t'(d))
                DIR_N:
                begin
                    ok = (y != GRID_MAX);
                    ny = y + 1'b1;
                end
                DIR_E:
                begin
                    ok = (x != GRID_MAX);
                    nx = x + 1'b1;
                end
                DIR_S:
                begin
                    ok = (y != '0);
                    ny = y - 1'b1;
                end
                DIR_W:
                begin
                    ok = (x != '0);
                    nx = x - 1'b1;
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
            return {ok, nx, ny};
        end
    endfunction

    // Manhattan distance between two cells.
    function automatic logic [HDIST_W-1:0] mdist(input logic [COORD_W-1:0] x1,
                                                 input logic [COORD_W-1:0] y1,
                                                 input logic [COORD_W-1:0] x2,
                                                 input logic [COORD_W-1:0] y2);
        logic [COORD_W-1:0] a;
        logic [COORD_W-1:0] b;
        begin
            a = (x1 > x2) ? (x1 - x2) : (x2 - x1);
            b = (y1 > y2) ? (y1 - y2) : (y2 - y1);
            return HDIST_W'(a) + HDIST_W'(b);
        end
    endfunction

endpackage

// File: sv/maze_astar_path_planner.sv
`timescale 1ns / 1ps
// A mark writes the wall on both sides of the cell edge when the neighbor is on the grid; a plan
//   pops the open heap and sifts it down, expands each neighbor with a sift up, and traces the
//   path back from the goal before the response is handed over.
// One transaction is handled at a time; the heap and node-total memory reads set the pace.
// Reset: wall map reads as empty and the stored path length is zero; there is no clearing pass.
// ----------------------------------------------------------------------------
// Maze A* path planner
// Request front end with an output register around the search engine.
// ----------------------------------------------------------------------------
module maze_astar_path_planner
    import mazp_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  mazp_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output mazp_rsp_t rsp
);

    eng_ctl_t  ctl;
    eng_sts_t  sts;
    mazp_rsp_t eng_rsp;
    logic      rsp_valid_reg;
    mazp_rsp_t rsp_reg;
    logic      out_load;

    // A new request transaction is taken whenever the engine is idle, even
    // while the previous response still waits in the output register.
    assign req_stall = sts.busy;
    assign ctl.go    = req_valid && !sts.busy;

    // The engine hands over its result once the output register is free or
    // is being emptied in the same cycle.
    assign out_load  = sts.done && (!rsp_valid_reg || !rsp_stall);
    assign ctl.take  = out_load;

    mazp_engine #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (req),
        .sts   (sts),
        .rsp   (eng_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload is held while stalled.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_reg <= eng_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: sv/mazp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze planner search engine
// Holds the wall map, node tables, open heap and path store in synchronous
// memories and runs one request at a time with a sequencer.
// ----------------------------------------------------------------------------
module mazp_engine
    import mazp_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  eng_ctl_t  ctl,
    input  mazp_req_t req,
    output eng_sts_t  sts,
    output mazp_rsp_t rsp
);

    localparam int HW    = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int IX_W  = HW + 2;
    localparam int CG_W  = COST_W + CELL_W;

    typedef enum logic [4:0] {
        S_IDLE, S_MARK1, S_MARK2, S_READ1,
        S_POP, S_POP1, S_POP2, S_SD0, S_SD1, S_SD2,
        S_CHECK, S_LOAD, S_EXPD, S_EXP1, S_SU0, S_SU1, S_SU2,
        S_TR0, S_TR1, S_DONE
    } state_t;

    // Memories.
    logic [3:0]        wall_mem [NCELL];
    logic [TOT_W-1:0]  tot_mem  [NCELL];
    logic [CG_W-1:0]   cg_mem   [NCELL];
    logic [CELL_W-1:0] heap_mem [HEAP_DEPTH];
    logic [CELL_W-1:0] path_mem [NCELL];

    // Memory ports.
    logic [CELL_W-1:0] wall_ra, wall_wa;
    logic              wall_we;
    logic [3:0]        wall_wd, wall_rd, wall_q;
    logic              wall_rvld_reg;
    logic [CELL_W-1:0] tot_ra0, tot_ra1, tot_wa;
    logic              tot_we;
    logic [TOT_W-1:0]  tot_wd, tot_rd0, tot_rd1;
    logic [CELL_W-1:0] cg_ra, cg_wa;
    logic              cg_we;
    logic [CG_W-1:0]   cg_wd, cg_rd;
    logic [HW-1:0]     heap_ra0, heap_ra1, heap_wa;
    logic              heap_we;
    logic [CELL_W-1:0] heap_wd, heap_rd0, heap_rd1;
    logic [CELL_W-1:0] path_ra, path_wa;
    logic              path_we;
    logic [CELL_W-1:0] path_wd, path_rd;

    // Control and working registers.
    state_t             state_reg;
    mazp_req_t          req_reg;
    logic [LEN_W-1:0]   stored_len_reg;
    logic               ent_valid_reg;
    logic [COORD_W-1:0] ent_x_reg, ent_y_reg;
    logic [NCELL-1:0]   wall_vld_reg, present_reg, closed_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CELL_W-1:0]  cur_reg, mc_reg, hl_reg, hr_reg, hp_reg, n_reg, c_reg;
    logic [TOT_W-1:0]   mt_reg;
    logic [HW-1:0]      i_reg, p_reg;
    logic [IX_W-1:0]    l_reg;
    logic [1:0]         dir_reg;
    logic [3:0]         wall_cur_reg;
    logic [COST_W-1:0]  cost_cur_reg, g_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [CELL_W-1:0]  nbr_reg;

    // Decode helpers.
    logic [CELL_W-1:0]  req_cell, start_cell, goal_cell;
    logic [CELL_W:0]    mark_nb, exp_nb;
    logic               exp_skip, exp_upd, heap_full;
    logic [TOT_W-1:0]   new_tot;
    logic [IX_W-1:0]    sd_l, sd_r, cnt_x;
    logic               sd_stop, sd_pick_r, sd_done;
    logic [TOT_W-1:0]   sd_ts;
    logic [CELL_W-1:0]  sd_hs;
    logic [IX_W-1:0]    sd_s;
    logic [HW-1:0]      su_p;
    logic               su_stop;
    logic [LEN_W-1:0]   tr_len, read_addr;
    logic               tr_stop, read_hit;
    logic [CNT_W-1:0]   cnt_m1;

    assign req_cell   = {req.cell_x, req.cell_y};
    assign start_cell = {req_reg.cell_x, req_reg.cell_y};
    assign goal_cell  = {req_reg.goal_x, req_reg.goal_y};
    assign mark_nb    = step_cell(req_reg.cell_x, req_reg.cell_y, req_reg.wall_dir);
    assign exp_nb     = step_cell(cur_reg[CELL_W-1:COORD_W], cur_reg[COORD_W-1:0], dir_reg);
    assign exp_skip   = !exp_nb[CELL_W] || wall_cur_reg[dir_reg]
                        || closed_reg[exp_nb[CELL_W-1:0]];
    assign exp_upd    = !present_reg[n_reg] || (g_reg < cg_rd[CG_W-1:CELL_W]);
    assign new_tot    = TOT_W'(g_reg) + TOT_W'(mdist(n_reg[CELL_W-1:COORD_W],
                        n_reg[COORD_W-1:0], req_reg.goal_x, req_reg.goal_y));
    assign heap_full  = (cnt_reg >= CNT_W'(HEAP_DEPTH));
    assign cnt_x      = IX_W'(cnt_reg);
    assign cnt_m1     = cnt_reg - CNT_W'(1);
    assign sd_l       = IX_W'({i_reg, 1'b1});
    assign sd_stop    = (sd_l >= cnt_x);
    assign sd_r       = l_reg + IX_W'(1);
    assign sd_pick_r  = (sd_r < cnt_x) && (tot_rd1 < tot_rd0);
    assign sd_ts      = sd_pick_r ? tot_rd1 : tot_rd0;
    assign sd_hs      = sd_pick_r ? hr_reg : hl_reg;
    assign sd_s       = sd_pick_r ? sd_r : l_reg;
    assign sd_done    = (sd_ts >= mt_reg);
    assign su_p       = (i_reg - HW'(1)) >> 1;
    assign su_stop    = (tot_rd0 <= mt_reg);
    assign tr_len     = len_reg + LEN_W'(1);
    assign tr_stop    = (c_reg == start_cell) || (tr_len >= LEN_W'(NCELL));
    assign read_hit   = (LEN_W'(req.path_index) < stored_len_reg);
    assign read_addr  = stored_len_reg - LEN_W'(1) - LEN_W'(req.path_index);
    assign wall_q     = wall_rvld_reg ? wall_rd : 4'b0000;

    // Memory port steering.
    always_comb
    begin
        wall_ra  = req_cell;
        wall_we  = 1'b0;
        wall_wa  = start_cell;
        wall_wd  = wall_q;
        tot_ra0  = heap_rd0;
        tot_ra1  = heap_rd1;
        tot_we   = 1'b0;
        tot_wa   = n_reg;
        tot_wd   = new_tot;
        cg_ra    = n_reg;
        cg_we    = 1'b0;
        cg_wa    = n_reg;
        cg_wd    = {g_reg, cur_reg};
        heap_ra0 = '0;
        heap_ra1 = cnt_m1[HW-1:0];
        heap_we  = 1'b0;
        heap_wa  = i_reg;
        heap_wd  = mc_reg;
        path_ra  = read_addr[CELL_W-1:0];
        path_we  = 1'b0;
        path_wa  = len_reg[CELL_W-1:0];
        path_wd  = c_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.go && req_kind_t'(req.req_type) == REQ_PLAN)
                begin
                    tot_we  = 1'b1;
                    tot_wa  = req_cell;
                    tot_wd  = TOT_W'(mdist(req.cell_x, req.cell_y, req.goal_x, req.goal_y));
                    cg_we   = 1'b1;
                    cg_wa   = req_cell;
                    cg_wd   = {COST_W'(0), req_cell};
                    heap_we = 1'b1;
                    heap_wa = '0;
                    heap_wd = req_cell;
                end
            end
            S_MARK1:
            begin
                wall_we = 1'b1;
                wall_wa = start_cell;
                wall_wd = wall_q | (4'b0001 << req_reg.wall_dir);
                wall_ra = mark_nb[CELL_W-1:0];
            end
            S_MARK2:
            begin
                wall_we = 1'b1;
                wall_wa = nbr_reg;
                wall_wd = wall_q | (4'b0001 << (req_reg.wall_dir + 2'd2));
            end
            S_POP1:
            begin
                tot_ra0 = heap_rd1;
            end
            S_SD0:
            begin
                heap_ra0 = sd_l[HW-1:0];
                heap_ra1 = HW'(sd_l + IX_W'(1));
                heap_we  = sd_stop;
            end
            S_SD2:
            begin
                heap_we = 1'b1;
                heap_wd = sd_done ? mc_reg : sd_hs;
            end
            S_CHECK:
            begin
                wall_ra = cur_reg;
                cg_ra   = cur_reg;
            end
            S_EXPD:
            begin
                cg_ra   = exp_nb[CELL_W-1:0];
                tot_ra0 = exp_nb[CELL_W-1:0];
            end
            S_EXP1:
            begin
                tot_we = exp_upd;
                cg_we  = exp_upd;
            end
            S_SU0:
            begin
                heap_ra0 = su_p;
                heap_we  = (i_reg == '0);
            end
            S_SU2:
            begin
                heap_we = 1'b1;
                heap_wd = su_stop ? mc_reg : hp_reg;
            end
            S_TR0:
            begin
                path_we = 1'b1;
                cg_ra   = c_reg;
            end
            default:
            begin
                heap_we = 1'b0;
            end
        endcase
    end

    // Memories: one write and the listed reads per cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (wall_we)
        begin
            wall_mem[wall_wa] <= wall_wd;
        end
        wall_rd <= wall_mem[wall_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tot_we)
        begin
            tot_mem[tot_wa] <= tot_wd;
        end
        tot_rd0 <= tot_mem[tot_ra0];
        tot_rd1 <= tot_mem[tot_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (cg_we)
        begin
            cg_mem[cg_wa] <= cg_wd;
        end
        cg_rd <= cg_mem[cg_ra];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_wa] <= heap_wd;
        end
        heap_rd0 <= heap_mem[heap_ra0];
        heap_rd1 <= heap_mem[heap_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (path_we)
        begin
            path_mem[path_wa] <= path_wd;
        end
        path_rd <= path_mem[path_ra];
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            stored_len_reg <= '0;
            ent_valid_reg  <= 1'b0;
            ent_x_reg      <= '0;
            ent_y_reg      <= '0;
            wall_vld_reg   <= '0;
            wall_rvld_reg  <= 1'b0;
            present_reg    <= '0;
            closed_reg     <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            wall_rvld_reg <= wall_vld_reg[wall_ra];
            if (wall_we)
            begin
                wall_vld_reg[wall_wa] <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ctl.go)
                    begin
                        req_reg       <= req;
                        ent_valid_reg <= 1'b0;
                        ent_x_reg     <= '0;
                        ent_y_reg     <= '0;
                        unique case (req_kind_t'(req.req_type))
                            REQ_CLEAR:
                            begin
                                wall_vld_reg <= '0;
                                state_reg    <= S_DONE;
                            end
                            REQ_MARK:
                            begin
                                state_reg <= S_MARK1;
                            end
                            REQ_PLAN:
                            begin
                                // Only the start cell is known at the beginning of a plan.
                                present_reg <= NCELL'(1) << req_cell;
                                closed_reg  <= '0;
                                cnt_reg     <= CNT_W'(1);
                                state_reg   <= S_POP;
                            end
                            REQ_READ:
                            begin
                                state_reg <= read_hit ? S_READ1 : S_DONE;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MARK1:
                begin
                    nbr_reg   <= mark_nb[CELL_W-1:0];
                    state_reg <= mark_nb[CELL_W] ? S_MARK2 : S_DONE;
                end
                S_MARK2:
                begin
                    state_reg <= S_DONE;
                end
                S_READ1:
                begin
                    ent_valid_reg <= 1'b1;
                    ent_x_reg     <= path_rd[CELL_W-1:COORD_W];
                    ent_y_reg     <= path_rd[COORD_W-1:0];
                    state_reg     <= S_DONE;
                end
                S_POP:
                begin
                    if (cnt_reg == '0)
                    begin
                        stored_len_reg <= '0;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_POP1;
                    end
                end
                S_POP1:
                begin
                    cur_reg   <= heap_rd0;
                    mc_reg    <= heap_rd1;
                    cnt_reg   <= cnt_m1;
                    i_reg     <= '0;
                    state_reg <= (cnt_m1 == '0) ? S_CHECK : S_POP2;
                end
                S_POP2:
                begin
                    mt_reg    <= tot_rd0;
                    state_reg <= S_SD0;
                end
                S_SD0:
                begin
                    l_reg     <= sd_l;
                    state_reg <= sd_stop ? S_CHECK : S_SD1;
                end
                S_SD1:
                begin
                    hl_reg    <= heap_rd0;
                    hr_reg    <= heap_rd1;
                    state_reg <= S_SD2;
                end
                S_SD2:
                begin
                    if (sd_done)
                    begin
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        i_reg     <= HW'(sd_s);
                        state_reg <= S_SD0;
                    end
                end
                S_CHECK:
                begin
                    if (closed_reg[cur_reg])
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        closed_reg[cur_reg] <= 1'b1;
                        if (cur_reg == goal_cell)
                        begin
                            len_reg   <= '0;
                            c_reg     <= cur_reg;
                            state_reg <= S_TR0;
                        end
                        else
                        begin
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_LOAD:
                begin
                    wall_cur_reg <= wall_q;
                    cost_cur_reg <= cg_rd[CG_W-1:CELL_W];
                    dir_reg      <= '0;
                    state_reg    <= S_EXPD;
                end
                S_EXPD:
                begin
                    if (exp_skip)
                    begin
                        dir_reg   <= dir_reg + 2'd1;
                        state_reg <= (dir_reg == 2'd3) ? S_POP : S_EXPD;
                    end
                    else
                    begin
                        n_reg     <= exp_nb[CELL_W-1:0];
                        g_reg     <= cost_cur_reg + COST_W'(1);
                        state_reg <= S_EXP1;
                    end
                end
                S_EXP1:
                begin
                    if (exp_upd)
                    begin
                        present_reg[n_reg] <= 1'b1;
                    end
                    if (heap_full)
                    begin
                        dir_reg   <= dir_reg + 2'd1;
                        state_reg <= (dir_reg == 2'd3) ? S_POP : S_EXPD;
                    end
                    else
                    begin
                        i_reg     <= cnt_reg[HW-1:0];
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                        mc_reg    <= n_reg;
                        mt_reg    <= exp_upd ? new_tot : tot_rd0;
                        state_reg <= S_SU0;
                    end
                end
                S_SU0:
                begin
                    if (i_reg == '0)
                    begin
                        dir_reg   <= dir_reg + 2'd1;
                        state_reg <= (dir_reg == 2'd3) ? S_POP : S_EXPD;
                    end
                    else
                    begin
                        p_reg     <= su_p;
                        state_reg <= S_SU1;
                    end
                end
                S_SU1:
                begin
                    hp_reg    <= heap_rd0;
                    state_reg <= S_SU2;
                end
                S_SU2:
                begin
                    if (su_stop)
                    begin
                        dir_reg   <= dir_reg + 2'd1;
                        state_reg <= (dir_reg == 2'd3) ? S_POP : S_EXPD;
                    end
                    else
                    begin
                        i_reg     <= p_reg;
                        state_reg <= S_SU0;
                    end
                end
                S_TR0:
                begin
                    len_reg <= tr_len;
                    if (tr_stop)
                    begin
                        stored_len_reg <= tr_len;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_TR1;
                    end
                end
                S_TR1:
                begin
                    c_reg     <= cg_rd[CELL_W-1:0];
                    state_reg <= S_TR0;
                end
                S_DONE:
                begin
                    if (ctl.take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign sts.busy = (state_reg != S_IDLE);
    assign sts.done = (state_reg == S_DONE);

    assign rsp.path_len    = stored_len_reg;
    assign rsp.path_found  = (stored_len_reg != '0);
    assign rsp.entry_valid = ent_valid_reg;
    assign rsp.path_x      = ent_x_reg;
    assign rsp.path_y      = ent_y_reg;

`ifndef SYNTHESIS
    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(HEAP_DEPTH))
        else $error("open heap count exceeds its depth");

    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.go |-> state_reg == S_IDLE)
        else $error("request started while the engine is busy");

    a_take_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && ctl.take) |=> state_reg == S_IDLE)
        else $error("engine did not release after its result was taken");

    a_sift_child: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SD2 |-> l_reg < cnt_x)
        else $error("sift down compared a child beyond the heap");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze planner testbench
// Drives clear, wall, plan and read transactions into the maze planner with
// random gaps and stalls, and checks every response against an A* predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import mazp_pkg::*;

    // Scoreboard: holds the planner state as the block should see it and the
    // queue of responses still owed by the block.
    class maze_scoreboard;
        logic [3:0] walls[NCELL];
        logic [7:0] route[NCELL];
        int         route_len;
        mazp_rsp_t  owed[$];
        int         mismatches;

        function void reset_state();
            foreach (walls[i])
            begin
                walls[i] = '0;
            end
            route_len  = 0;
            mismatches = 0;
        endfunction

        // A* search with a min-heap on f, duplicates allowed.
        function int search(int sx, int sy, int gx, int gy);
            bit  closed[NCELL];
            bit  seen[NCELL];
            int  gcost[NCELL];
            int  fcost[NCELL];
            int  parent[NCELL];
            int  heap[$];
            int  cnt;
            int  cur;
            int  i;
            int  p;
            int  l;
            int  s;
            int  t;
            int  n;
            int  g;
            int  nx;
            int  ny;
            int  len;
            int  c;
            int  dx[4];
            int  dy[4];
            dx = '{0, 1, 0, -1};
            dy = '{1, 0, -1, 0};
            heap = {};
            cnt = 0;
            seen[sx * GRID_SIDE + sy] = 1;
            gcost[sx * GRID_SIDE + sy] = 0;
            fcost[sx * GRID_SIDE + sy] = (sx > gx ? sx - gx : gx - sx)
                                       + (sy > gy ? sy - gy : gy - sy);
            parent[sx * GRID_SIDE + sy] = sx * GRID_SIDE + sy;
            heap.push_back(sx * GRID_SIDE + sy);
            cnt = 1;
            while (cnt > 0)
            begin
                cur = heap[0];
                cnt--;
                heap[0] = heap[cnt];
                void'(heap.pop_back());
                i = 0;
                forever
                begin
                    l = 2 * i + 1;
                    if (l >= cnt) break;
                    s = l;
                    if (l + 1 < cnt && fcost[heap[l + 1]] < fcost[heap[l]]) s = l + 1;
                    if (fcost[heap[s]] >= fcost[heap[i]]) break;
                    t = heap[s]; heap[s] = heap[i]; heap[i] = t;
                    i = s;
                end
                if (closed[cur]) continue;
                closed[cur] = 1;
                if (cur == gx * GRID_SIDE + gy)
                begin
                    len = 0;
                    c = cur;
                    forever
                    begin
                        route[len] = c[7:0];
                        len++;
                        if (c == sx * GRID_SIDE + sy || len >= NCELL) break;
                        c = parent[c];
                    end
                    for (i = 0; i < len / 2; i++)
                    begin
                        t = int'(route[i]);
                        route[i] = route[len - 1 - i];
                        route[len - 1 - i] = t[7:0];
                    end
                    return len;
                end
                for (int d = 0; d < 4; d++)
                begin
                    nx = cur / GRID_SIDE + dx[d];
                    ny = cur % GRID_SIDE + dy[d];
                    if (nx < 0 || nx >= GRID_SIDE || ny < 0 || ny >= GRID_SIDE) continue;
                    if (walls[cur][d]) continue;
                    n = nx * GRID_SIDE + ny;
                    if (closed[n]) continue;
                    g = gcost[cur] + 1;
                    if (!seen[n] || g < gcost[n])
                    begin
                        seen[n]   = 1;
                        gcost[n]  = g;
                        fcost[n]  = g + (nx > gx ? nx - gx : gx - nx)
                                      + (ny > gy ? ny - gy : gy - ny);
                        parent[n] = cur;
                    end
                    heap.push_back(n);
                    cnt++;
                    i = cnt - 1;
                    while (i > 0)
                    begin
                        p = (i - 1) / 2;
                        if (fcost[heap[p]] <= fcost[heap[i]]) break;
                        t = heap[p]; heap[p] = heap[i]; heap[i] = t;
                        i = p;
                    end
                end
            end
            return 0;
        endfunction

        // Applies an accepted request and queues the response it owes.
        function void note_request(mazp_req_t r);
            mazp_rsp_t e;
            int        nx;
            int        ny;
            e = '0;
            case (req_kind_t'(r.req_type))
                REQ_CLEAR:
                begin
                    foreach (walls[i])
                    begin
                        walls[i] = '0;
                    end
                end
                REQ_MARK:
                begin
                    walls[r.cell_x * GRID_SIDE + r.cell_y][r.wall_dir] = 1'b1;
                    nx = int'(r.cell_x) + ((r.wall_dir == DIR_E) ? 1 : 0)
                                        - ((r.wall_dir == DIR_W) ? 1 : 0);
                    ny = int'(r.cell_y) + ((r.wall_dir == DIR_N) ? 1 : 0)
                                        - ((r.wall_dir == DIR_S) ? 1 : 0);
                    if (nx >= 0 && nx < GRID_SIDE && ny >= 0 && ny < GRID_SIDE)
                        walls[nx * GRID_SIDE + ny][(r.wall_dir + 2) % 4] = 1'b1;
                end
                REQ_PLAN:
                begin
                    route_len = search(int'(r.cell_x), int'(r.cell_y),
                                       int'(r.goal_x), int'(r.goal_y));
                end
                default:
                begin
                    if (r.path_index < route_len)
                    begin
                        e.entry_valid = 1'b1;
                        e.path_x      = route[r.path_index][7:4];
                        e.path_y      = route[r.path_index][3:0];
                    end
                end
            endcase
            e.path_len   = route_len[8:0];
            e.path_found = (route_len != 0);
            owed.push_back(e);
        endfunction

        function void check_response(mazp_rsp_t a);
            mazp_rsp_t e;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %p", a);
                return;
            end
            e = owed.pop_front();
            if (a !== e)
            begin
                mismatches++;
                if (mismatches <= 10) $display("response mismatch: expected %p, got %p", e, a);
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    mazp_req_t       req;
    logic            rsp_valid;
    logic            rsp_stall;
    mazp_rsp_t       rsp;
    maze_scoreboard  board;
    bit              hold_off;
    bit              hold_done;

    maze_astar_path_planner i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one, and runs with none.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one transaction and waits until the block takes it.
    task automatic send(mazp_req_t r);
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        board.note_request(r);
    endtask

    // Sends a transaction with a random gap in front of it.
    task automatic send_gapped(mazp_req_t r);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            req       <= mazp_req_t'({$urandom, $urandom});
            repeat (g) @(posedge clk);
        end
        send(r);
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (board.owed.size() != 0) @(posedge clk);
    endtask

    function automatic mazp_req_t make_req(req_kind_t k, int x, int y, int d,
                                           int gx, int gy, int idx);
        mazp_req_t r;
        r.req_type   = k;
        r.cell_x     = x[3:0];
        r.cell_y     = y[3:0];
        r.wall_dir   = d[1:0];
        r.goal_x     = gx[3:0];
        r.goal_y     = gy[3:0];
        r.path_index = idx[7:0];
        return r;
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int g;
        rsp_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_off && !hold_done)
            begin
                rsp_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_done = 1'b1;
            end
            g = gap_len();
            if (g > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // Responses are sampled at the same edge that accepts them.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall) board.check_response(rsp);
    end

    initial
    begin
        #50_000_000;
        $display("maze_astar_path_planner test failed");
        $finish;
    end

    initial
    begin
        mazp_req_t r;
        int        k;
        int        phase;
        board = new();
        board.reset_state();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        hold_off  = 1'b0;
        hold_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed: reads before any plan, start equals goal, corner to
        // corner on an empty map, walls on every side including at the
        // edges, a fully blocked goal, reads past the end, and a clear that
        // keeps the stored path.
        send(make_req(REQ_READ, 0, 0, 0, 0, 0, 0));
        send(make_req(REQ_PLAN, 5, 5, 0, 5, 5, 0));
        send(make_req(REQ_READ, 0, 0, 0, 0, 0, 0));
        send(make_req(REQ_READ, 0, 0, 0, 0, 0, 1));
        send(make_req(REQ_PLAN, 0, 0, 0, 15, 15, 0));
        send(make_req(REQ_READ, 0, 0, 0, 0, 0, 30));
        send(make_req(REQ_READ, 0, 0, 0, 0, 0, 31));
        send(make_req(REQ_READ, 0, 0, 0, 0, 0, 255));
        send(make_req(REQ_MARK, 15, 15, DIR_N, 0, 0, 0));
        send(make_req(REQ_MARK, 15, 15, DIR_E, 0, 0, 0));
        send(make_req(REQ_MARK, 0, 0, DIR_S, 0, 0, 0));
        send(make_req(REQ_MARK, 0, 0, DIR_W, 0, 0, 0));
        send(make_req(REQ_MARK, 15, 14, DIR_N, 0, 0, 0));
        send(make_req(REQ_MARK, 14, 15, DIR_E, 0, 0, 0));
        send(make_req(REQ_PLAN, 0, 0, 0, 15, 15, 0));
        send(make_req(REQ_READ, 0, 0, 0, 0, 0, 0));
        send(make_req(REQ_MARK, 8, 8, DIR_N, 0, 0, 0));
        send(make_req(REQ_MARK, 8, 8, DIR_S, 0, 0, 0));
        send(make_req(REQ_MARK, 8, 8, DIR_E, 0, 0, 0));
        send(make_req(REQ_PLAN, 8, 8, 0, 0, 15, 0));
        send(make_req(REQ_READ, 8, 8, 0, 0, 0, 3));
        send(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
        send(make_req(REQ_READ, 0, 0, 0, 0, 0, 2));

        // Random phases: each builds a maze, plans through it and reads the
        // route back. One phase runs under a long receiver hold-off, and
        // one phase waits for every response before it starts.
        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 2) hold_off = 1'b1;
            if (phase == 4) wait_drain();
            send_gapped(make_req(REQ_CLEAR, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom));
            k = $urandom_range(2, 12);
            repeat (k)
            begin
                r = mazp_req_t'({$urandom, $urandom});
                r.req_type = REQ_MARK;
                send_gapped(r);
            end
            repeat (2)
            begin
                r = mazp_req_t'({$urandom, $urandom});
                r.req_type = REQ_PLAN;
                send_gapped(r);
                repeat ($urandom_range(3, 6))
                begin
                    r = mazp_req_t'({$urandom, $urandom});
                    r.req_type   = REQ_READ;
                    r.path_index = (board.route_len > 0 && $urandom_range(0, 3) != 0)
                                   ? 8'($urandom_range(0, board.route_len))
                                   : 8'($urandom);
                    send_gapped(r);
                end
            end
            // A little noise of any kind.
            repeat ($urandom_range(0, 3))
            begin
                send_gapped(mazp_req_t'({$urandom, $urandom}));
            end
        end
        wait_drain();
        repeat (50) @(posedge clk);

        if (board.mismatches == 0 && board.owed.size() == 0)
        begin
            $display("maze_astar_path_planner test passed");
        end
        else
        begin
            $display("maze_astar_path_planner test failed");
        end
        $finish;
    end
endmodule
